// ===== hw/rtl/ppm_pkg.sv =====
// ----------------------------------------------------------------------------
// PPM frame decoder package
// Shared constants and types for the PPM frame decoder.
// ----------------------------------------------------------------------------
package ppm_pkg;

  localparam int NUM_CHANNELS = 8;
  localparam int CH_AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CNT_W = $clog2(NUM_CHANNELS + 1);

  localparam int STAMP_W = 16;
  localparam int CLAMP_W = 15;
  localparam int CFG_IW  = 2;

  localparam logic       CMD_CAPTURE = 1'b0;
  localparam logic       CMD_READ    = 1'b1;

  localparam logic [CFG_IW-1:0] REG_TIMER_TOP      = 2'd0;
  localparam logic [CFG_IW-1:0] REG_SYNC_THRESHOLD = 2'd1;
  localparam logic [CFG_IW-1:0] REG_MIN_WIDTH      = 2'd2;
  localparam logic [CFG_IW-1:0] REG_MAX_WIDTH      = 2'd3;

  localparam logic [STAMP_W-1:0] TIMER_TOP_RST      = 16'd39999;
  localparam logic [STAMP_W-1:0] SYNC_THRESHOLD_RST = 16'd8000;
  localparam logic [CLAMP_W-1:0] MIN_WIDTH_RST      = 15'd1000;
  localparam logic [CLAMP_W-1:0] MAX_WIDTH_RST      = 15'd2000;

  typedef struct packed {
    logic is_read;
    logic hit;
    logic flag;
  } ppm_s1_t;

endpackage

// ===== hw/rtl/ppm_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with a registered read.
// ----------------------------------------------------------------------------
module ppm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/ppm_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// PPM frame decoder
// Stages: s1 (with the RAM read), then the result register.
// Throughput: one item per cycle while in_stall is low; the slot store is at
// most one RAM read or write per item; an output stall backs up to in_stall.
// Reset: synchronous rst_n clears the counters, flag and slot valid bits and
// reloads the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module ppm_frame_decoder
  import ppm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IW-1:0]    cfg_index,
  input  logic [STAMP_W-1:0]   cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_cmd,
  input  logic [STAMP_W-1:0]   in_capture_time,
  input  logic [2:0]           in_channel,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [CLAMP_W-1:0]   out_channel_width,
  output logic                 out_frame_ok
);

  logic [STAMP_W-1:0] timer_top_r, sync_thr_r;
  logic [CLAMP_W-1:0] min_w_r, max_w_r;

  logic [STAMP_W-1:0] last_r, last_nxt;
  logic [CNT_W-1:0]   nch_r, nch_nxt;
  logic               flag_r, flag_nxt;
  logic [NUM_CHANNELS-1:0] vld_r, vld_nxt;

  logic               s1_v_r;
  ppm_s1_t            s1_r, s1_nxt;
  logic               out_v_r;
  logic [CLAMP_W-1:0] out_w_r, out_w_nxt;
  logic               out_f_r;

  logic               s1_adv, acc;
  logic [STAMP_W-1:0] width;
  logic               wr_en;
  logic [CH_AW-1:0]   wr_addr, rd_addr;
  logic               in_range;
  logic [STAMP_W-1:0] rd_data;
  logic [CLAMP_W-1:0] half;

  assign s1_adv   = s1_v_r && (!out_v_r || !out_stall);
  assign in_stall = s1_v_r && !s1_adv;
  assign acc      = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_top_r <= TIMER_TOP_RST;
      sync_thr_r  <= SYNC_THRESHOLD_RST;
      min_w_r     <= MIN_WIDTH_RST;
      max_w_r     <= MAX_WIDTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TIMER_TOP:      timer_top_r <= cfg_wdata;
        REG_SYNC_THRESHOLD: sync_thr_r  <= cfg_wdata;
        REG_MIN_WIDTH:      min_w_r     <= cfg_wdata[CLAMP_W-1:0];
        REG_MAX_WIDTH:      max_w_r     <= cfg_wdata[CLAMP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (in_capture_time < last_r) begin
      width = in_capture_time + timer_top_r - last_r;
    end else begin
      width = in_capture_time - last_r;
    end
    in_range = {2'b00, in_channel} < 5'(NUM_CHANNELS);
    rd_addr  = CH_AW'({{CH_AW{1'b0}}, in_channel});
    wr_addr  = CH_AW'(nch_r);

    last_nxt = last_r;
    nch_nxt  = nch_r;
    flag_nxt = flag_r;
    vld_nxt  = vld_r;
    wr_en    = 1'b0;
    s1_nxt   = s1_r;

    if (acc) begin
      if (in_cmd == CMD_CAPTURE) begin
        last_nxt = in_capture_time;
        if (width > sync_thr_r) begin
          nch_nxt = '0;
        end else if (nch_r < CNT_W'(NUM_CHANNELS)) begin
          wr_en            = 1'b1;
          vld_nxt[wr_addr] = 1'b1;
          nch_nxt          = nch_r + 1'b1;
          if (nch_nxt >= CNT_W'(NUM_CHANNELS)) begin
            flag_nxt = 1'b1;
          end
        end
        s1_nxt.is_read = 1'b0;
        s1_nxt.hit     = 1'b0;
        s1_nxt.flag    = flag_nxt;
      end else begin
        s1_nxt.is_read = 1'b1;
        s1_nxt.hit     = in_range && vld_r[rd_addr];
        s1_nxt.flag    = flag_r;
        flag_nxt       = 1'b0;
      end
    end
  end

  ppm_ram #(
    .WIDTH (STAMP_W),
    .DEPTH (NUM_CHANNELS)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (width),
    .re    (acc && (in_cmd == CMD_READ)),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_comb begin
    half = s1_r.hit ? rd_data[STAMP_W-1:1] : '0;
    if (!s1_r.is_read) begin
      out_w_nxt = '0;
    end else if (half < min_w_r) begin
      out_w_nxt = min_w_r;
    end else if (half > max_w_r) begin
      out_w_nxt = max_w_r;
    end else begin
      out_w_nxt = half;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r  <= '0;
      nch_r   <= '0;
      flag_r  <= 1'b0;
      vld_r   <= '0;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      last_r <= last_nxt;
      nch_r  <= nch_nxt;
      flag_r <= flag_nxt;
      vld_r  <= vld_nxt;
      if (acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_r <= s1_nxt;
    end
    if (s1_adv) begin
      out_w_r <= out_w_nxt;
      out_f_r <= s1_r.flag;
    end
  end

  assign out_valid         = out_v_r;
  assign out_channel_width = out_w_r;
  assign out_frame_ok      = out_f_r;

endmodule
